FILE: rtl/cfp_pkg.sv
// shared types and constants for the countdown frame parser
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

    // longest frame accepted as valid, in bytes
    localparam logic [8:0] MAX_FRAME = 9'd128;
    // shortest possible frame: two header bytes, count byte, checksum
    localparam logic [8:0] MIN_FRAME = 9'd4;
    // byte index of the entry count
    localparam logic [7:0] POS_COUNT = 8'd2;
    // byte index of the first entry control byte
    localparam logic [7:0] POS_ENTRY = 8'd3;
    localparam logic [7:0] POS_LAST  = 8'd255;

    // colour code in control bits 1..0
    localparam logic [1:0] COLOUR_DARK   = 2'b00;
    localparam logic [1:0] COLOUR_GREEN  = 2'b01;
    localparam logic [1:0] COLOUR_YELLOW = 2'b10;
    localparam logic [1:0] COLOUR_RED    = 2'b11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } cfp_in_t;

    typedef struct packed {
        logic       frame_ok;
        logic       channel_found;
        logic [7:0] green_count;
        logic [7:0] yellow_count;
        logic [7:0] red_count;
        logic       green_new;
        logic       yellow_new;
        logic       red_new;
        logic       dark_mode;
        logic       blind_mode;
    } cfp_out_t;

    // frame verdict handed from the frame tracker to the top level
    typedef struct packed {
        logic       ok;
        logic       found;
        logic [7:0] ctl;
        logic [7:0] val;
    } cfp_frame_end_t;

endpackage

`default_nettype wire

FILE: rtl/cfp_frame_track.sv
// per-frame tracking: position, running xor, entry count and matching entry
`timescale 1ns / 1ps
`default_nettype none

module cfp_frame_track
    import cfp_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire cfp_in_t        in_data,
    input  wire logic [4:0]     channel,
    output cfp_frame_end_t      frame_end
);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] total_reg, total_next;
    logic [7:0] hold_reg, hold_next;
    logic       found_reg, found_next;
    logic [7:0] ctl_reg, ctl_next;
    logic [7:0] val_reg, val_next;

    logic [7:0] offset;
    logic       in_entries;
    logic [8:0] frame_len;
    logic [9:0] need_len;

    assign offset     = pos_reg - POS_ENTRY;
    assign in_entries = (pos_reg >= POS_ENTRY) && ({1'b0, offset[7:1]} < total_reg);
    assign frame_len  = {1'b0, pos_reg} + 9'd1;
    assign need_len   = {1'b0, total_reg, 1'b0} + 10'd4;

    always_comb begin
        frame_end.ok    = (frame_len >= MIN_FRAME) && (frame_len <= MAX_FRAME)
                          && ({1'b0, frame_len} == need_len)
                          && (xor_reg == in_data.data_byte);
        frame_end.found = frame_end.ok && found_reg;
        frame_end.ctl   = ctl_reg;
        frame_end.val   = val_reg;
    end

    always_comb begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        total_next = total_reg;
        hold_next  = hold_reg;
        found_next = found_reg;
        ctl_next   = ctl_reg;
        val_next   = val_reg;
        if (accept) begin
            if (in_data.last_byte) begin
                // every frame end restarts the per-frame state
                pos_next   = '0;
                xor_next   = '0;
                total_next = '0;
                hold_next  = '0;
                found_next = 1'b0;
                ctl_next   = '0;
                val_next   = '0;
            end else begin
                if (pos_reg == POS_COUNT) begin
                    total_next = in_data.data_byte;
                end
                if (pos_reg >= POS_COUNT) begin
                    xor_next = xor_reg ^ in_data.data_byte;
                end
                if (in_entries) begin
                    if (!offset[0]) begin
                        hold_next = in_data.data_byte;
                    end else if (!found_reg && (hold_reg[7:3] == channel)) begin
                        found_next = 1'b1;
                        ctl_next   = hold_reg;
                        val_next   = in_data.data_byte;
                    end
                end
                if (pos_reg != POS_LAST) begin
                    pos_next = pos_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            xor_reg   <= '0;
            total_reg <= '0;
            hold_reg  <= '0;
            found_reg <= 1'b0;
            ctl_reg   <= '0;
            val_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            total_reg <= total_next;
            hold_reg  <= hold_next;
            found_reg <= found_next;
            ctl_reg   <= ctl_next;
            val_reg   <= val_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/countdown_frame_parser.sv
// top level of the countdown frame parser: persistent counts and result register
//
//   channel   direction  ports                       payload
//   input     in         s_valid / s_ready / s_data  cfp_in_t, one frame byte
//   result    out        m_valid / m_ready / m_data  cfp_out_t, one per frame end
//   config    in         cfg_valid / cfg_ready       cfg_data, 5-bit channel number
//
// one byte per cycle while s_ready is high: each byte goes through the frame tracker and
// the count update in the cycle it is taken, and a frame's result sits in the result register
// in the cycle after its checksum byte is taken
// s_ready drops only while a result waits and m_ready is low
// synchronous active-low reset clears counts, flags, channel and frame state
`timescale 1ns / 1ps
`default_nettype none

module countdown_frame_parser
    import cfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input byte stream
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire cfp_in_t    s_data,
    // frame results
    output logic            m_valid,
    input  wire logic       m_ready,
    output cfp_out_t        m_data,
    // channel register write
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_data
);

    logic           s_accept;
    cfp_frame_end_t frame_end;

    // configured channel
    logic [4:0] channel_reg;

    // persistent counts and sticky flags
    logic [7:0] green_reg, green_next;
    logic [7:0] yellow_reg, yellow_next;
    logic [7:0] red_reg, red_next;
    logic [3:0] flags_reg, flags_next;   // green, yellow, red, dark from bit 0
    logic       blind_reg, blind_next;

    // result register
    logic       m_valid_reg;
    cfp_out_t   m_data_reg;
    cfp_out_t   result;

    // take a byte whenever the result slot is free or being emptied
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    cfp_frame_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .in_data   (s_data),
        .channel   (channel_reg),
        .frame_end (frame_end)
    );

    // apply the held entry of a valid frame at its checksum byte
    always_comb begin
        green_next  = green_reg;
        yellow_next = yellow_reg;
        red_next    = red_reg;
        flags_next  = flags_reg;
        blind_next  = blind_reg;
        if (s_accept && s_data.last_byte && frame_end.found) begin
            unique case (frame_end.ctl[1:0])
                COLOUR_GREEN: begin
                    green_next    = frame_end.val;
                    flags_next[0] = 1'b1;
                end
                COLOUR_YELLOW: begin
                    yellow_next   = frame_end.val;
                    flags_next[1] = 1'b1;
                end
                COLOUR_RED: begin
                    red_next      = frame_end.val;
                    flags_next[2] = 1'b1;
                end
                COLOUR_DARK: begin
                    flags_next[3] = 1'b1;
                end
            endcase
            blind_next = frame_end.ctl[2];
        end
    end

    // result as seen after this frame's update
    always_comb begin
        result.frame_ok      = frame_end.ok;
        result.channel_found = frame_end.found;
        result.green_count   = green_next;
        result.yellow_count  = yellow_next;
        result.red_count     = red_next;
        result.green_new     = flags_next[0];
        result.yellow_new    = flags_next[1];
        result.red_new       = flags_next[2];
        result.dark_mode     = flags_next[3];
        result.blind_mode    = blind_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg <= '0;
            green_reg   <= '0;
            yellow_reg  <= '0;
            red_reg     <= '0;
            flags_reg   <= '0;
            blind_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                channel_reg <= cfg_data;
            end
            green_reg  <= green_next;
            yellow_reg <= yellow_next;
            red_reg    <= red_next;
            flags_reg  <= flags_next;
            blind_reg  <= blind_next;
            // a checksum byte loads a request into the result slot
            if (s_accept && s_data.last_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept && s_data.last_byte) begin
            m_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

FILE: verif/cfp_checker.sv
// scoreboard for the countdown frame parser: frame predictor and result compare
`timescale 1ns / 1ps

module cfp_checker
    import cfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire cfp_in_t    s_data,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire cfp_out_t   m_data,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [4:0] cfg_data,
    output int              mismatches,
    output int              outstanding
);

    // predictor copy of the channel register
    logic [4:0] chan_sel;

    // per-frame tracking
    logic [7:0] pos;
    logic [7:0] xor_acc;
    logic [7:0] n_entries;
    logic [7:0] ctl_latch;
    logic       hit;
    logic [7:0] hit_ctl;
    logic [7:0] hit_val;

    // persistent counts and flags
    logic [7:0] green_cnt;
    logic [7:0] yellow_cnt;
    logic [7:0] red_cnt;
    logic       green_seen;
    logic       yellow_seen;
    logic       red_seen;
    logic       dark_seen;
    logic       blind_bit;

    cfp_out_t frame_results_q[$];
    int       mismatch_total = 0;

    assign mismatches = mismatch_total;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_bit(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0b want %0b", name, got, want));
    endtask

    task automatic clear_frame();
        pos       = '0;
        xor_acc   = '0;
        n_entries = '0;
        ctl_latch = '0;
        hit       = 1'b0;
        hit_ctl   = '0;
        hit_val   = '0;
    endtask

    task automatic take_byte(input cfp_in_t req);
        int       idx;
        int       slot;
        int       frame_len;
        logic     ok;
        cfp_out_t res;
        idx = int'(pos);
        if (!req.last_byte) begin
            if (idx == POS_COUNT)
                n_entries = req.data_byte;
            if (idx >= POS_COUNT)
                xor_acc ^= req.data_byte;
            slot = idx - POS_ENTRY;
            if (idx >= POS_ENTRY && (slot >> 1) < n_entries) begin
                if ((slot % 2) == 0) begin
                    ctl_latch = req.data_byte;
                end else if (!hit && ctl_latch[7:3] == chan_sel) begin
                    hit     = 1'b1;
                    hit_ctl = ctl_latch;
                    hit_val = req.data_byte;
                end
            end
            if (pos != POS_LAST)
                pos++;
        end else begin
            frame_len = idx + 1;
            ok = frame_len >= MIN_FRAME && frame_len <= MAX_FRAME &&
                 frame_len == 2 * n_entries + 4 && xor_acc == req.data_byte;
            if (ok && hit) begin
                case (hit_ctl[1:0])
                    COLOUR_GREEN: begin
                        green_cnt  = hit_val;
                        green_seen = 1'b1;
                    end
                    COLOUR_YELLOW: begin
                        yellow_cnt  = hit_val;
                        yellow_seen = 1'b1;
                    end
                    COLOUR_RED: begin
                        red_cnt  = hit_val;
                        red_seen = 1'b1;
                    end
                    default: begin
                        dark_seen = 1'b1;
                    end
                endcase
                blind_bit = hit_ctl[2];
            end
            res.frame_ok      = ok;
            res.channel_found = ok && hit;
            res.green_count   = green_cnt;
            res.yellow_count  = yellow_cnt;
            res.red_count     = red_cnt;
            res.green_new     = green_seen;
            res.yellow_new    = yellow_seen;
            res.red_new       = red_seen;
            res.dark_mode     = dark_seen;
            res.blind_mode    = blind_bit;
            frame_results_q.push_back(res);
            clear_frame();
        end
    endtask

    task automatic check_result(input cfp_out_t got);
        cfp_out_t want;
        if (frame_results_q.size() == 0) begin
            report_mismatch("result with no frame end pending");
        end else begin
            want = frame_results_q.pop_front();
            check_bit("frame_ok", got.frame_ok, want.frame_ok);
            check_bit("channel_found", got.channel_found, want.channel_found);
            check_field("green_count", got.green_count, want.green_count);
            check_field("yellow_count", got.yellow_count, want.yellow_count);
            check_field("red_count", got.red_count, want.red_count);
            check_bit("green_new", got.green_new, want.green_new);
            check_bit("yellow_new", got.yellow_new, want.yellow_new);
            check_bit("red_new", got.red_new, want.red_new);
            check_bit("dark_mode", got.dark_mode, want.dark_mode);
            check_bit("blind_mode", got.blind_mode, want.blind_mode);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            chan_sel    = '0;
            green_cnt   = '0;
            yellow_cnt  = '0;
            red_cnt     = '0;
            green_seen  = 1'b0;
            yellow_seen = 1'b0;
            red_seen    = 1'b0;
            dark_seen   = 1'b0;
            blind_bit   = 1'b0;
            clear_frame();
            frame_results_q.delete();
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (cfg_valid && cfg_ready)
                chan_sel = cfg_data;
            if (s_valid && s_ready)
                take_byte(s_data);
        end
        outstanding <= frame_results_q.size();
    end

endmodule

FILE: verif/testbench.sv
// top of the countdown frame parser testbench: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module testbench;
    import cfp_pkg::*;

    // cycles with no request moving on any channel before the run is called hung
    localparam int STALL_LIMIT   = 1000;
    // result lands in the cycle after its checksum byte; this wait lets the block settle
    localparam int SETTLE_CYCLES = 4;
    // bytes per random phase, four phases in all
    localparam int PHASE_BYTES   = 260;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    cfp_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    cfp_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    int         mismatches;
    int         outstanding;

    // idling knobs for the current phase, in percent
    int         sender_idle_pct = 0;
    int         recv_stall_pct  = 0;
    // channel the block answers to right now, used to steer entries onto it
    logic [4:0] cur_channel     = '0;
    int         bytes_sent      = 0;
    int         quiet_cycles    = 0;
    // bytes of the frame being assembled
    logic [7:0] frame_q[$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    countdown_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    cfp_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side: stall at random, one draw per cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: any request moving on any channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one byte request; idle gaps go in front so valid never drops once raised
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cfp_in_t'{data_byte: data, last_byte: last};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // send the assembled frame, end mark on its final byte
    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // append the checksum: xor from the count byte on, optionally spoiled
    task automatic seal_frame(input logic [7:0] corrupt);
        logic [7:0] sum = '0;
        for (int i = POS_COUNT; i < frame_q.size(); i++)
            sum ^= frame_q[i];
        frame_q.push_back(sum ^ corrupt);
    endtask

    // control/value pairs, half of them addressed to the live channel
    task automatic push_entries(input int n);
        logic [4:0] chan;
        repeat (n) begin
            chan = $urandom_range(1) ? cur_channel : 5'($urandom);
            frame_q.push_back({chan, 3'($urandom)});
            frame_q.push_back(8'($urandom));
        end
    endtask

    // wait until every result is back and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // channel register write, only ever issued while the block is idle
    task automatic write_channel(input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid   <= 1'b0;
        cur_channel = value;
    endtask

    // one random frame: mostly well formed, the rest broken in assorted ways
    task automatic random_frame();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 4) begin
            // runt frame, one to three bytes
            repeat ($urandom_range(3, 1))
                frame_q.push_back(8'($urandom));
        end else if (pick < 8) begin
            // line noise with stray end marks, then a terminating byte
            repeat ($urandom_range(12, 1))
                send_byte(8'($urandom), $urandom_range(3) == 0);
            frame_q.push_back(8'($urandom));
        end else begin
            if (pick < 11)
                n = 62;                         // longest frame that still fits
            else if (pick < 13)
                n = 63;                         // two bytes past the length limit
            else if (pick < 14)
                n = 126 + $urandom_range(1);    // position counter runs into saturation
            else
                n = $urandom_range(6);
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'(n));
            push_entries(n);
            // length disagrees with the entry count
            if (pick >= 14 && pick < 22) begin
                if ($urandom_range(1) && frame_q.size() > 3)
                    void'(frame_q.pop_back());
                else
                    frame_q.push_back(8'($urandom));
            end
            // bad checksum
            if (pick >= 22 && pick < 30)
                seal_frame(8'($urandom_range(255, 1)));
            else
                seal_frame(8'h00);
        end
        send_frame();
    endtask

    // random phase under one idling setting and one channel
    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [4:0] chan);
        int   stop_at;
        logic paused;
        write_channel(chan);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        stop_at         = bytes_sent + PHASE_BYTES;
        paused          = 1'b0;
        while (bytes_sent < stop_at) begin
            random_frame();
            // halfway through, hold off until every result has come back
            if (!paused && bytes_sent >= stop_at - PHASE_BYTES / 2) begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames, channel 0
        write_channel(5'd0);
        // lone checksum byte: far too short
        frame_q = '{8'hFF};
        send_frame();
        // three bytes: still short
        frame_q = '{8'h00, 8'hFF, 8'h00};
        send_frame();
        // no entries; the checksum byte looks like a channel 0 control but is not one
        frame_q = '{8'hAA, 8'h55, 8'h00};
        seal_frame(8'h00);
        send_frame();
        // first entry on another channel, second one is ours: red with blind set
        frame_q = '{8'h12, 8'h34, 8'h02, {5'd5, 1'b0, COLOUR_GREEN}, 8'h10,
                    {5'd0, 1'b1, COLOUR_RED}, 8'hFF};
        seal_frame(8'h00);
        send_frame();
        // green entry for us but the checksum is off: nothing may change
        frame_q = '{8'h00, 8'h00, 8'h01, {5'd0, 1'b0, COLOUR_GREEN}, 8'h00};
        seal_frame(8'h80);
        send_frame();
        // dark entry, blind cleared
        frame_q = '{8'h01, 8'h02, 8'h01, {5'd0, 1'b0, COLOUR_DARK}, 8'h7E};
        seal_frame(8'h00);
        send_frame();
        drain();

        // random phases: no idling, sender idle, receiver stall, both
        run_phase(0, 0, 5'd31);
        run_phase(60, 0, 5'($urandom));
        run_phase(0, 60, 5'd0);
        run_phase(32, 32, 5'($urandom_range(30, 1)));

        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cfp_pkg.sv
rtl/cfp_frame_track.sv
rtl/countdown_frame_parser.sv
verif/cfp_checker.sv
verif/testbench.sv
